// ===== src/vrac_pkg.sv =====
// ----------------------------------------------------------------------------
// Video row address counter package
// Shared types, mode tables, divide helpers and the sequencer microprogram.
// ----------------------------------------------------------------------------
package vrac_pkg;

    // Meaning of the input mode field.
    typedef enum logic [1:0] {
        MODE_REG_WRITE  = 2'd0,
        MODE_FIELD_SYNC = 2'd1,
        MODE_HSYNC      = 2'd2,
        MODE_FETCH      = 2'd3
    } t_mode;

    // Datapath operation selected by one control word.
    typedef enum logic [2:0] {
        OP_NONE         = 3'd0,
        OP_REG_WRITE    = 3'd1,
        OP_FIELD_SYNC   = 3'd2,
        OP_LINE_ADVANCE = 3'd3,
        OP_LINE_MASK    = 3'd4,
        OP_FETCH_CHUNK  = 3'd5,
        OP_EMIT         = 3'd6
    } t_op;

    // How the step counter moves after a control word.
    typedef enum logic [2:0] {
        COND_NEXT     = 3'd0,
        COND_JUMP     = 3'd1,
        COND_MORE     = 3'd2,
        COND_DISPATCH = 3'd3,
        COND_OUTPUT   = 3'd4
    } t_cond;

    typedef logic [2:0] t_upc;

    // Microprogram addresses.
    localparam t_upc UA_IDLE  = 3'd0;
    localparam t_upc UA_REGWR = 3'd1;
    localparam t_upc UA_FSYNC = 3'd2;
    localparam t_upc UA_HADV  = 3'd3;
    localparam t_upc UA_HMASK = 3'd4;
    localparam t_upc UA_FETCH = 3'd5;
    localparam t_upc UA_DONE  = 3'd6;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_upc  target;
    } t_uop;

    // Control handed from the sequencer to the datapath.
    typedef struct packed {
        t_op  op;
        logic load;
    } t_ctrl;

    // Status returned from the datapath to the sequencer.
    typedef struct packed {
        logic more;
    } t_status;

    // Per graphics mode tables.
    localparam logic [1:0] X_DIV [8] = '{2'd1, 2'd3, 2'd1, 2'd2, 2'd1, 2'd1, 2'd1, 2'd1};
    localparam logic [3:0] Y_DIV [8] = '{4'd12, 4'd1, 4'd3, 4'd1, 4'd2, 4'd1, 4'd1, 4'd1};
    localparam logic [4:0] LINE_ADD [8] =
        '{5'd16, 5'd8, 5'd16, 5'd8, 5'd16, 5'd8, 5'd16, 5'd0};
    localparam logic [15:0] LINE_MASK [8] = '{16'hFFE1, 16'hFFF1, 16'hFFE1, 16'hFFF1,
                                             16'hFFE1, 16'hFFF1, 16'hFFE1, 16'hFFFF};

    // Display base: control bits 3 to 9 placed at address bits 9 to 15.
    function automatic logic [15:0] base_of(input logic [15:0] ctrl);
        return {ctrl[9:3], 9'd0};
    endfunction

    // Next X divide count, wrapped by the divisor of the mode.
    function automatic logic [1:0] x_wrap(input logic [2:0] gmode, input logic [1:0] x);
        logic [2:0] v;
        logic [2:0] r;
        v = {1'b0, x} + 3'd1;
        r = 3'd0;
        case (X_DIV[gmode])
            2'd2:    r = {2'd0, v[0]};
            2'd3:    r = (v >= 3'd3) ? v - 3'd3 : v;
            default: r = 3'd0;
        endcase
        return r[1:0];
    endfunction

    // Next Y divide count, wrapped by the divisor of the mode.
    function automatic logic [3:0] y_wrap(input logic [2:0] gmode, input logic [3:0] y);
        logic [4:0] v;
        v = {1'b0, y} + 5'd1;
        case (Y_DIV[gmode])
            4'd2: v = {4'd0, v[0]};
            4'd3: begin
                for (int i = 0; i < 5; i++) begin
                    if (v >= 5'd3) begin
                        v = v - 5'd3;
                    end
                end
            end
            4'd12: v = (v >= 5'd12) ? v - 5'd12 : v;
            default: v = 5'd0;
        endcase
        return v[3:0];
    endfunction

    // Entry point of the microprogram for each input mode.
    function automatic t_upc entry_of(input t_mode m);
        t_upc e;
        unique case (m)
            MODE_REG_WRITE:  e = UA_REGWR;
            MODE_FIELD_SYNC: e = UA_FSYNC;
            MODE_HSYNC:      e = UA_HADV;
            MODE_FETCH:      e = UA_FETCH;
            default:         e = UA_IDLE;
        endcase
        return e;
    endfunction

    // Microprogram read-only table.
    function automatic t_uop ucode(input t_upc pc);
        t_uop u;
        unique case (pc)
            UA_IDLE:  u = '{op: OP_NONE,         cond: COND_DISPATCH, target: UA_IDLE};
            UA_REGWR: u = '{op: OP_REG_WRITE,    cond: COND_JUMP,     target: UA_DONE};
            UA_FSYNC: u = '{op: OP_FIELD_SYNC,   cond: COND_JUMP,     target: UA_DONE};
            UA_HADV:  u = '{op: OP_LINE_ADVANCE, cond: COND_NEXT,     target: UA_IDLE};
            UA_HMASK: u = '{op: OP_LINE_MASK,    cond: COND_JUMP,     target: UA_DONE};
            UA_FETCH: u = '{op: OP_FETCH_CHUNK,  cond: COND_MORE,     target: UA_FETCH};
            UA_DONE:  u = '{op: OP_EMIT,         cond: COND_OUTPUT,   target: UA_IDLE};
            default:  u = '{op: OP_NONE,         cond: COND_JUMP,     target: UA_IDLE};
        endcase
        return u;
    endfunction

endpackage

// ===== src/vrac_datapath.sv =====
// ----------------------------------------------------------------------------
// Video row address counter datapath
// Control register, row address and divide counters, driven by control words.
// ----------------------------------------------------------------------------
module vrac_datapath (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  vrac_pkg::t_ctrl        i_ctl,
    input  logic [7:0]             i_reg_bit_address,
    input  logic                   i_sync_level,
    input  logic [7:0]             i_fetch_count,
    output vrac_pkg::t_status      o_status,
    output logic [15:0]            o_row_address,
    output logic [15:0]            o_control_bits
);

    logic [15:0] r_ctrl, n_ctrl;
    logic [15:0] r_addr, n_addr;
    logic [1:0]  r_xcnt, n_xcnt;
    logic [3:0]  r_ycnt, n_ycnt;
    logic [7:0]  r_waddr;
    logic        r_level;
    logic [7:0]  r_count, n_count;

    logic [2:0]  gmode;
    logic [4:0]  room;
    logic [4:0]  chunk;
    logic [7:0]  count_rest;
    logic [4:0]  adv_n;
    logic [15:0] sum;
    logic [1:0]  x_nx;
    logic [3:0]  y_nx;
    logic [15:0] adv_addr;
    logic [1:0]  adv_x;
    logic [3:0]  adv_y;
    logic [15:0] bit_sel;

    assign gmode = r_ctrl[2:0];

    // Fetch chunk: up to the next 16-byte boundary or the remaining count.
    assign room       = 5'd16 - {1'b0, r_addr[3:0]};
    assign chunk      = (r_count < {3'd0, room}) ? r_count[4:0] : room;
    assign count_rest = r_count - {3'd0, chunk};

    // Shared advance unit with the boundary rewind of the divide counters.
    assign adv_n = (i_ctl.op == vrac_pkg::OP_FETCH_CHUNK) ? chunk : vrac_pkg::LINE_ADD[gmode];
    assign sum   = r_addr + {11'd0, adv_n};
    assign x_nx  = vrac_pkg::x_wrap(gmode, r_xcnt);
    assign y_nx  = vrac_pkg::y_wrap(gmode, r_ycnt);

    always_comb begin
        adv_addr = sum;
        adv_x    = r_xcnt;
        adv_y    = r_ycnt;
        if (r_addr[4] != sum[4]) begin
            adv_x = x_nx;
            if (x_nx != 2'd0) begin
                adv_addr = sum - 16'h0010;
            end else if (r_addr[5] != sum[5]) begin
                adv_y = y_nx;
                if (y_nx != 4'd0) begin
                    adv_addr = sum - 16'h0020;
                end
            end
        end
    end

    assign bit_sel = 16'd1 << r_waddr[4:1];

    // Next state for the operation of this step.
    always_comb begin
        n_ctrl  = r_ctrl;
        n_addr  = r_addr;
        n_xcnt  = r_xcnt;
        n_ycnt  = r_ycnt;
        n_count = r_count;
        unique case (i_ctl.op)
            vrac_pkg::OP_REG_WRITE: begin
                if (r_waddr[7:5] == 3'd0) begin
                    n_ctrl = r_waddr[0] ? (r_ctrl | bit_sel) : (r_ctrl & ~bit_sel);
                end
            end
            vrac_pkg::OP_FIELD_SYNC: begin
                if (r_level) begin
                    n_addr = vrac_pkg::base_of(r_ctrl);
                    n_xcnt = 2'd0;
                    n_ycnt = 4'd0;
                end
            end
            vrac_pkg::OP_LINE_ADVANCE: begin
                if (!r_level) begin
                    n_addr = adv_addr;
                    n_xcnt = adv_x;
                    n_ycnt = adv_y;
                end
            end
            vrac_pkg::OP_LINE_MASK: begin
                if (!r_level) begin
                    n_addr = r_addr & vrac_pkg::LINE_MASK[gmode];
                end
            end
            vrac_pkg::OP_FETCH_CHUNK: begin
                n_addr  = adv_addr;
                n_xcnt  = adv_x;
                n_ycnt  = adv_y;
                n_count = count_rest;
            end
            default: begin
            end
        endcase
    end

    // Architectural state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= 16'd0;
            r_addr <= 16'd0;
            r_xcnt <= 2'd0;
            r_ycnt <= 4'd0;
        end else begin
            r_ctrl <= n_ctrl;
            r_addr <= n_addr;
            r_xcnt <= n_xcnt;
            r_ycnt <= n_ycnt;
        end
    end

    // Operands of the item in work, captured on the input transfer.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_waddr <= i_reg_bit_address;
            r_level <= i_sync_level;
            r_count <= i_fetch_count;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_status.more  = (count_rest != 8'd0);
    assign o_row_address  = r_addr;
    assign o_control_bits = r_ctrl;

endmodule

// ===== src/video_row_address_counter.sv =====
// ----------------------------------------------------------------------------
// Video row address counter
// Microcoded sequencer over the address datapath, with a registered output.
// ----------------------------------------------------------------------------
// One item is worked at a time. A register write or a field sync runs its own
// step and then the emit step, a horizontal sync runs the line advance, line
// mask and emit steps, and a byte fetch runs one chunk step per 16-byte chunk
// (at least one), so up to seventeen chunk steps for a count of 255, then the
// emit step. The chunk loop of the microprogram, which runs the single shared
// advance unit once per step, sets the fetch time. A new item is taken as soon
// as the sequencer is back at its idle step, even while the last result waits
// in the output register; the emit step holds until that register is free.
module video_row_address_counter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_reg_bit_address,
    input  logic        i_sync_level,
    input  logic [7:0]  i_fetch_count,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_row_address,
    output logic [15:0] o_display_base,
    output logic [2:0]  o_video_mode,
    output logic [15:0] o_control_register
);

    vrac_pkg::t_upc    r_upc, n_upc;
    vrac_pkg::t_uop    uop;
    vrac_pkg::t_ctrl   ctl;
    vrac_pkg::t_status status;
    logic              in_accept;
    logic              out_free;
    logic              emit;
    logic [15:0]       row_address;
    logic [15:0]       control_bits;

    logic              r_out_valid;
    logic [15:0]       r_row_address;
    logic [15:0]       r_control;

    // Control word of the current step.
    assign uop        = vrac_pkg::ucode(r_upc);
    assign o_in_stall = (r_upc != vrac_pkg::UA_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign emit       = (uop.op == vrac_pkg::OP_EMIT) && out_free;

    assign ctl.op   = uop.op;
    assign ctl.load = in_accept;

    // Step counter sequencing.
    always_comb begin
        unique case (uop.cond)
            vrac_pkg::COND_NEXT:     n_upc = 3'(r_upc + 3'd1);
            vrac_pkg::COND_JUMP:     n_upc = uop.target;
            vrac_pkg::COND_MORE:     n_upc = status.more ? uop.target : 3'(r_upc + 3'd1);
            vrac_pkg::COND_DISPATCH: n_upc = in_accept ?
                                             vrac_pkg::entry_of(vrac_pkg::t_mode'(i_mode)) :
                                             r_upc;
            vrac_pkg::COND_OUTPUT:   n_upc = out_free ? uop.target : r_upc;
            default:                 n_upc = vrac_pkg::UA_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= vrac_pkg::UA_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    vrac_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctl             (ctl),
        .i_reg_bit_address (i_reg_bit_address),
        .i_sync_level      (i_sync_level),
        .i_fetch_count     (i_fetch_count),
        .o_status          (status),
        .o_row_address     (row_address),
        .o_control_bits    (control_bits)
    );

    // Output register: filled by the emit step, emptied by an output transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_row_address <= row_address;
            r_control     <= control_bits;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_row_address      = r_row_address;
    assign o_display_base     = vrac_pkg::base_of(r_control);
    assign o_video_mode       = r_control[2:0];
    assign o_control_register = r_control;

endmodule

// ===== tb/video_row_address_counter_checker.sv =====
// ----------------------------------------------------------------------------
// Video row address counter checker
// Watches both channels of the block and keeps its own copy of the control
// register, the row address and the X and Y divide counters. Each accepted
// input transfer is worked through that copy to form the expected result.
// Each accepted output transfer is then compared field by field with the
// oldest expected result.
// ----------------------------------------------------------------------------
module video_row_address_counter_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_reg_bit_address,
    input  logic        i_sync_level,
    input  logic [7:0]  i_fetch_count,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [15:0] i_row_address,
    input  logic [15:0] i_display_base,
    input  logic [2:0]  i_video_mode,
    input  logic [15:0] i_control_register,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [15:0] row;
        logic [15:0] base;
        logic [2:0]  gmode;
        logic [15:0] ctrl;
    } t_row_result;

    // Per graphics mode row geometry: divisors, line increment and line mask.
    typedef struct packed {
        logic [3:0]  xdiv;
        logic [3:0]  ydiv;
        logic [4:0]  add;
        logic [15:0] mask;
    } t_line_geom;

    logic [15:0]  ctrl_q;
    logic [15:0]  row_q;
    int unsigned  x_q;
    int unsigned  y_q;
    t_row_result  result_q[$];

    function automatic t_line_geom geom_of(input logic [2:0] g);
        t_line_geom r;
        case (g)
            3'd0:    r = '{4'd1, 4'd12, 5'd16, 16'hFFE1};
            3'd1:    r = '{4'd3, 4'd1,  5'd8,  16'hFFF1};
            3'd2:    r = '{4'd1, 4'd3,  5'd16, 16'hFFE1};
            3'd3:    r = '{4'd2, 4'd1,  5'd8,  16'hFFF1};
            3'd4:    r = '{4'd1, 4'd2,  5'd16, 16'hFFE1};
            3'd5:    r = '{4'd1, 4'd1,  5'd8,  16'hFFF1};
            3'd6:    r = '{4'd1, 4'd1,  5'd16, 16'hFFE1};
            default: r = '{4'd1, 4'd1,  5'd0,  16'hFFFF};
        endcase
        return r;
    endfunction

    // Advance the row by n; a 16-byte crossing may rewind it so rows repeat.
    task automatic advance_row(input int n);
        t_line_geom  g;
        logic [15:0] prev;
        logic [15:0] nxt;
        g    = geom_of(ctrl_q[2:0]);
        prev = row_q;
        nxt  = 16'(prev + n);
        if (((prev ^ nxt) & 16'h0010) != 16'd0) begin
            x_q = (x_q + 1) % g.xdiv;
            if (x_q != 0) begin
                nxt = nxt - 16'h0010;
            end else if (((prev ^ nxt) & 16'h0020) != 16'd0) begin
                y_q = (y_q + 1) % g.ydiv;
                if (y_q != 0) begin
                    nxt = nxt - 16'h0020;
                end
            end
        end
        row_q = nxt;
    endtask

    // Byte fetch: move in chunks that stop on 16-byte boundaries.
    task automatic fetch_row(input int n);
        int left;
        int room;
        int chunk;
        left = n;
        while (left > 0) begin
            room  = 16 - int'(row_q[3:0]);
            chunk = (room < left) ? room : left;
            if (chunk < room) begin
                row_q = 16'(row_q + chunk);
            end else begin
                advance_row(chunk);
            end
            left = left - chunk;
        end
    endtask

    // Apply one input transfer to the shadow state and queue its result.
    task automatic apply_item(input logic [1:0] m, input logic [7:0] waddr,
                              input logic level, input logic [7:0] count);
        t_line_geom  g;
        logic [15:0] base;
        case (vrac_pkg::t_mode'(m))
            vrac_pkg::MODE_REG_WRITE: begin
                if (waddr <= 8'd31) begin
                    ctrl_q[waddr[4:1]] = waddr[0];
                end
            end
            vrac_pkg::MODE_FIELD_SYNC: begin
                if (level) begin
                    row_q = (ctrl_q & 16'h03F8) << 6;
                    x_q   = 0;
                    y_q   = 0;
                end
            end
            vrac_pkg::MODE_HSYNC: begin
                if (!level) begin
                    g = geom_of(ctrl_q[2:0]);
                    advance_row(g.add);
                    row_q = row_q & g.mask;
                end
            end
            default: begin
                fetch_row(count);
            end
        endcase
        base = (ctrl_q & 16'h03F8) << 6;
        result_q.push_back('{row_q, base, ctrl_q[2:0], ctrl_q});
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            o_fail_count++;
        end
    endtask

    // Predict on input transfers and compare on output transfers.
    always @(posedge i_clk) begin
        t_row_result want;
        if (!i_rst_n) begin
            ctrl_q = 16'd0;
            row_q  = 16'd0;
            x_q    = 0;
            y_q    = 0;
            result_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                apply_item(i_mode, i_reg_bit_address, i_sync_level, i_fetch_count);
            end
            if (i_out_valid && !i_out_stall) begin
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual row %h ctrl %h",
                             $time, i_row_address, i_control_register);
                    o_fail_count++;
                end else begin
                    want = result_q.pop_front();
                    check_field("row_address", want.row, i_row_address);
                    check_field("display_base", want.base, i_display_base);
                    check_field("video_mode", {13'd0, want.gmode}, {13'd0, i_video_mode});
                    check_field("control_register", want.ctrl, i_control_register);
                end
            end
        end
        o_pending = result_q.size();
    end

endmodule

// ===== tb/video_row_address_counter_tb.sv =====
// ----------------------------------------------------------------------------
// Video row address counter testbench
// Drives register writes, field and line syncs and byte fetches into the
// block: a directed opening, then random display frames mixed with loose
// items, under three patterns of sender idling and receiver stalling. The
// checker beside the block predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module video_row_address_counter_tb;

    localparam int QUIET_LIMIT = 2000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  mode;
    logic [7:0]  reg_bit_address;
    logic        sync_level;
    logic [7:0]  fetch_count;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] row_address;
    logic [15:0] display_base;
    logic [2:0]  video_mode;
    logic [15:0] control_register;

    int fail_count;
    int pending;
    int send_idle_pct;
    int recv_stall_pct;
    int work_items;
    int quiet_cycles;
    logic in_taken;

    video_row_address_counter dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_stall         (in_stall),
        .i_mode             (mode),
        .i_reg_bit_address  (reg_bit_address),
        .i_sync_level       (sync_level),
        .i_fetch_count      (fetch_count),
        .o_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .o_row_address      (row_address),
        .o_display_base     (display_base),
        .o_video_mode       (video_mode),
        .o_control_register (control_register)
    );

    video_row_address_counter_checker row_check (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .i_in_stall         (in_stall),
        .i_mode             (mode),
        .i_reg_bit_address  (reg_bit_address),
        .i_sync_level       (sync_level),
        .i_fetch_count      (fetch_count),
        .i_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .i_row_address      (row_address),
        .i_display_base     (display_base),
        .i_video_mode       (video_mode),
        .i_control_register (control_register),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    // Clock with a period of two time units.
    always begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Remember whether the input transfer happened at the last rising edge.
    always @(posedge clk) begin
        in_taken <= in_valid && !in_stall;
    end

    // Receiver stalls at random, changing on the falling edge.
    always @(negedge clk) begin
        out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
    end

    // Watchdog: too many cycles without any transfer ends the run.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("** video_row_address_counter: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Send one item, called at a falling edge; returns at the falling edge
    // after the transfer.
    task automatic send_item(input logic [1:0] m, input logic [7:0] a,
                             input logic s, input logic [7:0] c);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid        <= 1'b1;
        mode            <= m;
        reg_bit_address <= a;
        sync_level      <= s;
        fetch_count     <= c;
        do @(negedge clk); while (!in_taken);
        // Only items that change something count toward the phase length.
        if (!((m == vrac_pkg::MODE_REG_WRITE && a > 8'd31) ||
              (m == vrac_pkg::MODE_FIELD_SYNC && !s) ||
              (m == vrac_pkg::MODE_HSYNC && s) ||
              (m == vrac_pkg::MODE_FETCH && c == 8'd0))) begin
            work_items++;
        end
    endtask

    // Hold the input off until every expected result has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
    endtask

    function automatic logic [7:0] pick_reg_address();
        int r;
        r = $urandom_range(99);
        if (r < 80) begin
            return 8'($urandom_range(19));
        end else if (r < 95) begin
            return 8'($urandom_range(31, 20));
        end
        return 8'($urandom_range(255, 32));
    endfunction

    function automatic logic [7:0] pick_fetch_count();
        int r;
        r = $urandom_range(99);
        if (r < 4) begin
            return 8'd255;
        end else if (r < 15) begin
            return 8'($urandom_range(255));
        end
        return 8'($urandom_range(48, 1));
    endfunction

    // One display frame: up to three register writes, usually a field sync, then
    // one-fetch scanlines closed by a line sync, with ignored sync levels mixed in.
    task automatic send_frame();
        int lines;
        repeat ($urandom_range(3)) begin
            send_item(vrac_pkg::MODE_REG_WRITE, pick_reg_address(), 1'($urandom_range(1)),
                      8'($urandom_range(255)));
        end
        if ($urandom_range(9) != 0) begin
            send_item(vrac_pkg::MODE_FIELD_SYNC, 8'($urandom_range(255)), 1'b1,
                      8'($urandom_range(255)));
        end
        lines = $urandom_range(24, 1);
        repeat (lines) begin
            send_item(vrac_pkg::MODE_FETCH, 8'($urandom_range(255)), 1'($urandom_range(1)),
                      pick_fetch_count());
            if ($urandom_range(19) == 0) begin
                send_item(vrac_pkg::MODE_HSYNC, 8'($urandom_range(255)), 1'b1,
                          8'($urandom_range(255)));
            end else if ($urandom_range(19) == 0) begin
                send_item(vrac_pkg::MODE_FIELD_SYNC, 8'($urandom_range(255)), 1'b0,
                          8'($urandom_range(255)));
            end
            send_item(vrac_pkg::MODE_HSYNC, 8'($urandom_range(255)), 1'b0,
                      8'($urandom_range(255)));
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int target);
        drain_results();
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        work_items     = 0;
        while (work_items < target) begin
            if ($urandom_range(99) < 75) begin
                send_frame();
            end else begin
                send_item(2'($urandom_range(3)), 8'($urandom_range(255)),
                          1'($urandom_range(1)), 8'($urandom_range(255)));
            end
            if ($urandom_range(199) == 0) begin
                drain_results();
            end
        end
    endtask

    initial begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        mode            = vrac_pkg::MODE_REG_WRITE;
        reg_bit_address = 8'd0;
        sync_level      = 1'b0;
        fetch_count     = 8'd0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        work_items      = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed opening: zero and full fetches, both sync levels, ignored
        // write addresses, the top register bit, and a mode change that can
        // leave the X counter out of the range of the new divisor.
        send_item(vrac_pkg::MODE_FETCH, 8'd0, 1'b0, 8'd0);
        send_item(vrac_pkg::MODE_FETCH, 8'hFF, 1'b1, 8'd255);
        send_item(vrac_pkg::MODE_HSYNC, 8'd0, 1'b0, 8'd0);
        send_item(vrac_pkg::MODE_HSYNC, 8'hFF, 1'b1, 8'hFF);
        send_item(vrac_pkg::MODE_REG_WRITE, 8'd255, 1'b1, 8'hFF);
        send_item(vrac_pkg::MODE_REG_WRITE, 8'd32, 1'b0, 8'd0);
        send_item(vrac_pkg::MODE_REG_WRITE, 8'd31, 1'b0, 8'd0);
        send_item(vrac_pkg::MODE_REG_WRITE, 8'd30, 1'b1, 8'd0);
        send_item(vrac_pkg::MODE_REG_WRITE, 8'd1, 1'b0, 8'd0);
        send_item(vrac_pkg::MODE_FETCH, 8'd0, 1'b0, 8'd255);
        send_item(vrac_pkg::MODE_REG_WRITE, 8'd2, 1'b0, 8'd0);
        send_item(vrac_pkg::MODE_FETCH, 8'd0, 1'b0, 8'd255);
        send_item(vrac_pkg::MODE_REG_WRITE, 8'd3, 1'b0, 8'd0);
        send_item(vrac_pkg::MODE_HSYNC, 8'd0, 1'b0, 8'd0);
        // Set bits 2 to 9: mode 7 and the highest display base.
        for (int b = 2; b <= 9; b++) begin
            send_item(vrac_pkg::MODE_REG_WRITE, 8'(2 * b + 1), 1'b0, 8'd0);
        end
        send_item(vrac_pkg::MODE_FIELD_SYNC, 8'd0, 1'b0, 8'd0);
        send_item(vrac_pkg::MODE_FIELD_SYNC, 8'd0, 1'b1, 8'd0);
        send_item(vrac_pkg::MODE_HSYNC, 8'd0, 1'b0, 8'd0);
        send_item(vrac_pkg::MODE_FETCH, 8'd0, 1'b0, 8'd255);

        run_phase(8, 69, 440);
        run_phase(69, 8, 440);
        run_phase(0, 0, 450);

        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (25) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("** video_row_address_counter: PASSED **");
        end else begin
            $display("** video_row_address_counter: FAILED **");
        end
        $finish;
    end

endmodule
